FILE: rtl/erc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the encounter rule classifier
package erc_pkg;

  // CORDIC datapath widths: scaled vector stays below 2^60 after gain
  localparam int XW           = 62;
  localparam int ZW           = 32;
  localparam int CORDIC_ITERS = 28;
  localparam int SCALE_TOP    = 58;

  // Configuration registers
  localparam int CFG_W = 15;
  localparam logic [CFG_W-1:0] HEAD_ON_RESET  = 15'd4099;
  localparam logic [CFG_W-1:0] CROSSING_RESET = 15'd20480;

  typedef enum logic [0:0] {
    REG_HEAD_ON  = 1'b0,
    REG_CROSSING = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_NONE        = 2'd0,
    CLS_HEAD_ON     = 2'd1,
    CLS_CROSS_RIGHT = 2'd2,
    CLS_CROSS_LEFT  = 2'd3
  } encounter_t;

  // atan(2^-i) as a fraction of a full turn, full turn = 2^32
  localparam logic [ZW-1:0] ATAN_TABLE [0:CORDIC_ITERS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5
  };

endpackage

FILE: rtl/erc_cordic_stage.sv
`timescale 1ns / 1ps
// One vectoring CORDIC iteration, registered, with side payload carried along
module erc_cordic_stage #(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  logic signed [erc_pkg::XW-1:0] x_in,
  input  logic signed [erc_pkg::XW-1:0] y_in,
  input  logic [erc_pkg::ZW-1:0]        z_in,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_v,
  output logic signed [erc_pkg::XW-1:0] x_out,
  output logic signed [erc_pkg::XW-1:0] y_out,
  output logic [erc_pkg::ZW-1:0]        z_out,
  output logic [SIDE_W-1:0]             side_out
);

  logic signed [erc_pkg::XW-1:0] xs;
  logic signed [erc_pkg::XW-1:0] ys;
  logic signed [erc_pkg::XW-1:0] x_next;
  logic signed [erc_pkg::XW-1:0] y_next;
  logic [erc_pkg::ZW-1:0]        z_next;

  // Rotate towards the x axis; direction follows the sign of y
  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    if (!y_in[erc_pkg::XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + erc_pkg::ATAN_TABLE[SHIFT];
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - erc_pkg::ATAN_TABLE[SHIFT];
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

FILE: rtl/encounter_rule_classifier.sv
`timescale 1ns / 1ps
// Registers from input transfer to result: stage 0, stage 1, the CORDIC iterations, bearing, output.
// Throughput: one item per cycle while not stalled; one registered CORDIC iteration per stage.
// An output stall with a valid result freezes the whole pipeline; input stall follows it directly.
// Reset: synchronous, clears all valid bits and loads the register defaults
// (head-on 4099, crossing 20480). No clearing pass is needed.
module encounter_rule_classifier #(
  parameter int POSITION_WIDTH = 24,
  parameter int ANGLE_WIDTH    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [0:0]                       cfg_index,
  input  logic [erc_pkg::CFG_W-1:0]        cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [POSITION_WIDTH-1:0] own_x,
  input  logic signed [POSITION_WIDTH-1:0] own_y,
  input  logic signed [ANGLE_WIDTH-1:0]    own_heading,
  input  logic signed [POSITION_WIDTH-1:0] target_x,
  input  logic signed [POSITION_WIDTH-1:0] target_y,
  input  logic signed [ANGLE_WIDTH-1:0]    target_heading,
  input  logic                             target_heading_known,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       encounter_class
);

  localparam int XW       = erc_pkg::XW;
  localparam int ZW       = erc_pkg::ZW;
  localparam int ITERS    = erc_pkg::CORDIC_ITERS;
  localparam int DW       = POSITION_WIDTH + 1;
  localparam int SCALE_SH = erc_pkg::SCALE_TOP - POSITION_WIDTH;
  localparam int CMPW     = ((ANGLE_WIDTH > erc_pkg::CFG_W) ? ANGLE_WIDTH : erc_pkg::CFG_W) + 1;
  localparam int SIDE_W   = ANGLE_WIDTH + 2;
  localparam logic [ZW-1:0] Z_RND = 32'd1 << (ZW - 1 - ANGLE_WIDTH);
  localparam logic [ZW-1:0] Z_HALF = 32'h8000_0000;
  localparam logic [ANGLE_WIDTH-1:0] A_HALF = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

  logic [erc_pkg::CFG_W-1:0] head_on_half_angle;
  logic [erc_pkg::CFG_W-1:0] crossing_limit;
  logic                      en;

  // Whole pipeline advances unless a finished result is held back
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_on_half_angle <= erc_pkg::HEAD_ON_RESET;
      crossing_limit     <= erc_pkg::CROSSING_RESET;
    end else if (cfg_write) begin
      case (erc_pkg::cfg_reg_t'(cfg_index))
        erc_pkg::REG_HEAD_ON:  head_on_half_angle <= cfg_data;
        erc_pkg::REG_CROSSING: crossing_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [CMPW-1:0] h_pos;
  logic signed [CMPW-1:0] h_neg;
  logic signed [CMPW-1:0] c_pos;
  logic signed [CMPW-1:0] c_neg;

  assign h_pos = $signed({{(CMPW-erc_pkg::CFG_W){1'b0}}, head_on_half_angle});
  assign c_pos = $signed({{(CMPW-erc_pkg::CFG_W){1'b0}}, crossing_limit});
  assign h_neg = -h_pos;
  assign c_neg = -c_pos;

  // ---------------- Stage 0: differences and heading check ----------------
  logic signed [DW-1:0]          dx_next;
  logic signed [DW-1:0]          dy_next;
  logic [ANGLE_WIDTH-1:0]        hdiff;
  logic signed [CMPW-1:0]        hdiff_ext;
  logic                          head_fail_next;

  always_comb begin
    dx_next = $signed({target_x[POSITION_WIDTH-1], target_x})
            - $signed({own_x[POSITION_WIDTH-1], own_x});
    dy_next = $signed({target_y[POSITION_WIDTH-1], target_y})
            - $signed({own_y[POSITION_WIDTH-1], own_y});
    // target heading minus the reciprocal of own heading, wrapped
    hdiff = ANGLE_WIDTH'(target_heading) - ANGLE_WIDTH'(own_heading) + A_HALF;
    hdiff_ext = $signed({{(CMPW-ANGLE_WIDTH){hdiff[ANGLE_WIDTH-1]}}, hdiff});
    head_fail_next = target_heading_known && ((hdiff_ext > h_pos) || (hdiff_ext < h_neg));
  end

  logic                          s0_v;
  logic signed [DW-1:0]          s0_dx;
  logic signed [DW-1:0]          s0_dy;
  logic [ANGLE_WIDTH-1:0]        s0_oh;
  logic                          s0_fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx   <= dx_next;
      s0_dy   <= dy_next;
      s0_oh   <= own_heading;
      s0_fail <= head_fail_next;
    end
  end

  // ---------------- Stage 1: scale, fold into right half-plane ----------------
  logic signed [XW-1:0] x_scaled;
  logic signed [XW-1:0] y_scaled;
  logic signed [XW-1:0] x_init;
  logic signed [XW-1:0] y_init;
  logic [ZW-1:0]        z_init;
  logic                 zero_next;

  always_comb begin
    x_scaled  = $signed({{(XW-DW){s0_dx[DW-1]}}, s0_dx}) <<< SCALE_SH;
    y_scaled  = $signed({{(XW-DW){s0_dy[DW-1]}}, s0_dy}) <<< SCALE_SH;
    zero_next = (s0_dx == '0) && (s0_dy == '0);
    if (s0_dx[DW-1]) begin
      x_init = -x_scaled;
      y_init = -y_scaled;
      z_init = Z_HALF;
    end else begin
      x_init = x_scaled;
      y_init = y_scaled;
      z_init = '0;
    end
  end

  logic                 s1_v;
  logic signed [XW-1:0] s1_x;
  logic signed [XW-1:0] s1_y;
  logic [ZW-1:0]        s1_z;
  logic [SIDE_W-1:0]    s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s0_v;
    end
  end

  // side payload: {coincident, heading check failed, own heading}
  always_ff @(posedge clk) begin
    if (en) begin
      s1_x    <= x_init;
      s1_y    <= y_init;
      s1_z    <= z_init;
      s1_side <= {zero_next, s0_fail, s0_oh};
    end
  end

  // ---------------- CORDIC iterations, one per stage ----------------
  logic                 cv    [0:ITERS];
  logic signed [XW-1:0] cx    [0:ITERS];
  logic signed [XW-1:0] cy    [0:ITERS];
  logic [ZW-1:0]        cz    [0:ITERS];
  logic [SIDE_W-1:0]    cside [0:ITERS];

  assign cv[0]    = s1_v;
  assign cx[0]    = s1_x;
  assign cy[0]    = s1_y;
  assign cz[0]    = s1_z;
  assign cside[0] = s1_side;

  for (genvar g = 0; g < ITERS; g++) begin : g_iter
    erc_cordic_stage #(
      .SHIFT  (g),
      .SIDE_W (SIDE_W)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_v     (cv[g]),
      .x_in     (cx[g]),
      .y_in     (cy[g]),
      .z_in     (cz[g]),
      .side_in  (cside[g]),
      .out_v    (cv[g+1]),
      .x_out    (cx[g+1]),
      .y_out    (cy[g+1]),
      .z_out    (cz[g+1]),
      .side_out (cside[g+1])
    );
  end

  // ---------------- Bearing: round angle, subtract own heading ----------------
  logic [ZW-1:0]          z_rounded;
  logic [ANGLE_WIDTH-1:0] atan_angle;
  logic [ANGLE_WIDTH-1:0] bearing_next;

  always_comb begin
    z_rounded  = cz[ITERS] + Z_RND;
    atan_angle = cside[ITERS][SIDE_W-1] ? '0 : z_rounded[ZW-1 -: ANGLE_WIDTH];
    bearing_next = atan_angle - cside[ITERS][ANGLE_WIDTH-1:0];
  end

  logic                   sb_v;
  logic [ANGLE_WIDTH-1:0] sb_bearing;
  logic                   sb_fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= 1'b0;
    end else if (en) begin
      sb_v <= cv[ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_bearing <= bearing_next;
      sb_fail    <= cside[ITERS][ANGLE_WIDTH];
    end
  end

  // ---------------- Sector classification ----------------
  logic signed [CMPW-1:0] b_ext;
  erc_pkg::encounter_t    class_next;

  always_comb begin
    b_ext = $signed({{(CMPW-ANGLE_WIDTH){sb_bearing[ANGLE_WIDTH-1]}}, sb_bearing});
    if ((b_ext >= h_neg) && (b_ext <= h_pos)) begin
      class_next = sb_fail ? erc_pkg::CLS_CROSS_LEFT : erc_pkg::CLS_HEAD_ON;
    end else if ((b_ext < h_neg) && (b_ext >= c_neg)) begin
      class_next = erc_pkg::CLS_CROSS_RIGHT;
    end else if ((b_ext > h_pos) && (b_ext <= c_pos)) begin
      class_next = erc_pkg::CLS_CROSS_LEFT;
    end else begin
      class_next = erc_pkg::CLS_NONE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      encounter_class <= class_next;
    end
  end

endmodule
